[rtl/sfs_pkg.sv]
package sfs_pkg;

    // configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 13;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_SHEET_WIDTH  = 3'd0;
    localparam cfg_idx_t REG_FRAME_WIDTH  = 3'd1;
    localparam cfg_idx_t REG_FRAME_HEIGHT = 3'd2;
    localparam cfg_idx_t REG_ORIGIN_X     = 3'd3;
    localparam cfg_idx_t REG_ORIGIN_Y     = 3'd4;
    localparam cfg_idx_t REG_FRAME_COUNT  = 3'd5;

    // field widths
    localparam int DIM_W    = 13;
    localparam int ORG_W    = 12;
    localparam int FCNT_W   = 7;
    localparam int ACT_W    = 2;
    localparam int DELTA_W  = 20;
    localparam int EIDX_W   = 6;
    localparam int EDUR_W   = 24;
    localparam int SRCX_W   = 12;
    localparam int SRCY_W   = 18;
    localparam int SHOWN_W  = 6;

    typedef logic [ACT_W-1:0] action_t;

    localparam action_t ACT_TICK    = 2'd0;
    localparam action_t ACT_WRITE   = 2'd1;
    localparam action_t ACT_RESTART = 2'd2;

    // reset values and limits
    localparam logic [DIM_W-1:0]  SHEET_WIDTH_RST  = 13'd256;
    localparam logic [DIM_W-1:0]  FRAME_WIDTH_RST  = 13'd32;
    localparam logic [DIM_W-1:0]  FRAME_HEIGHT_RST = 13'd32;
    localparam logic [FCNT_W-1:0] FRAME_COUNT_RST  = 7'd1;
    localparam logic [DIM_W-1:0]  DIM_MAX          = 13'd4096;
    localparam logic [31:0]       SRC_Y_MAX        = 32'd262143;

endpackage

[rtl/sprite_frame_sequencer.sv]
// channel   | handshake          | payload
// ----------+--------------------+--------------------------------------------------
// input     | s_valid / s_ready  | s_action, s_delta_us, s_entry_index, s_entry_duration
// result    | m_valid / m_ready  | m_src_x, m_src_y, m_shown_frame, m_advanced
// config    | cfg_we             | cfg_index, cfg_wdata (write only, no wait)
//
// write and restart transactions leave the input ready; a tick keeps it busy
// through two back-to-back 13-bit passes through the shared serial divider
// (frames per row, then row of the current frame)
// aresetn is synchronous; it clears frame index, elapsed time, registers, control
// the duration table has no reset; entries are defined once written
// a finished result waits in the output register while the next transaction is taken
module sprite_frame_sequencer #(
    parameter int MAX_FRAMES = 64,
    parameter int TIME_BITS  = 24
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_we,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sfs_pkg::CFG_W-1:0]         cfg_wdata,
    // input transactions
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [sfs_pkg::ACT_W-1:0]         s_action,
    input  logic [sfs_pkg::DELTA_W-1:0]       s_delta_us,
    input  logic [sfs_pkg::EIDX_W-1:0]        s_entry_index,
    input  logic [sfs_pkg::EDUR_W-1:0]        s_entry_duration,
    // result transactions
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sfs_pkg::SRCX_W-1:0]        m_src_x,
    output logic [sfs_pkg::SRCY_W-1:0]        m_src_y,
    output logic [sfs_pkg::SHOWN_W-1:0]       m_shown_frame,
    output logic                              m_advanced
);

    localparam int FI_W  = $clog2(MAX_FRAMES);
    localparam int CNT_W = FI_W + 1;
    localparam int ET_W  = TIME_BITS + 2;
    // wide enough for elapsed + delta, duration - elapsed and its double
    localparam int XW    = ((TIME_BITS + 2 > sfs_pkg::DELTA_W + 1) ?
                            TIME_BITS + 2 : sfs_pkg::DELTA_W + 1) + 2;
    localparam int PX_W  = FI_W + 14;
    localparam int DW    = sfs_pkg::DIM_W;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_ROWPR = 3'd3;
    localparam logic [2:0] S_ROW   = 3'd4;
    localparam logic [2:0] S_WAIT  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    // saturation bounds of elapsed time
    localparam logic signed [XW-1:0] ET_HI =
        signed'({{(XW-TIME_BITS-1){1'b0}}, {(TIME_BITS+1){1'b1}}});
    localparam logic signed [XW-1:0] ET_LO = ~ET_HI;

    logic [2:0] state_reg, state_next;

    // configuration registers
    logic [DW-1:0]                  sheet_width_reg;
    logic [DW-1:0]                  frame_width_reg;
    logic [DW-1:0]                  frame_height_reg;
    logic [sfs_pkg::ORG_W-1:0]      origin_x_reg;
    logic [sfs_pkg::ORG_W-1:0]      origin_y_reg;
    logic [sfs_pkg::FCNT_W-1:0]     frame_count_reg;

    // animation state
    logic [FI_W-1:0]                frame_index_reg;
    logic signed [ET_W-1:0]         elapsed_reg;

    // per-tick working registers
    logic [FI_W-1:0]                cur_reg;
    logic [sfs_pkg::DELTA_W-1:0]    delta_reg;
    logic signed [XW-1:0]           e_reg;
    logic signed [XW-1:0]           diff_reg;
    logic [DW-1:0]                  sw_reg;
    logic [DW-1:0]                  fw_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic [PX_W-1:0]                px_reg;
    logic [DW-1:0]                  per_row_reg;
    logic [PX_W-1:0]                sy_reg;
    logic                           adv_reg;
    logic signed [ET_W-1:0]         enew_reg;

    // output register
    logic                           m_valid_reg;
    logic [sfs_pkg::SRCX_W-1:0]     src_x_reg;
    logic [sfs_pkg::SRCY_W-1:0]     src_y_reg;
    logic [sfs_pkg::SHOWN_W-1:0]    shown_reg;
    logic                           advanced_reg;

    logic accept;
    logic take_tick;
    logic out_load;

    // clamped configuration
    logic [DW-1:0]    sw_c, fw_c;
    logic [CNT_W-1:0] cnt_c;
    logic [31:0]      fc32;

    // duration table
    logic [31:0]           idx32, dur32;
    logic                  ram_we;
    logic [FI_W-1:0]       ram_waddr;
    logic [TIME_BITS-1:0]  ram_wdata;
    logic [TIME_BITS-1:0]  ram_rdata;

    // time decision
    logic signed [XW:0]    dbl_diff;
    logic signed [XW:0]    delta_x;
    logic                  adv_c;
    logic signed [XW-1:0]  esel;
    logic signed [XW-1:0]  esat;

    // dividers
    logic             a_start, b_start, c_start;
    logic [DW-1:0]    a_dividend, a_divisor;
    logic             a_busy, b_busy, c_busy;
    logic [DW-1:0]    a_quo, a_rem;
    logic [PX_W-1:0]  b_quo;
    logic [DW-1:0]    b_rem;
    logic [CNT_W-1:0] c_quo, c_rem;

    logic [31:0]      sy32, cur32;

    assign accept    = s_valid && s_ready;
    assign take_tick = accept && (s_action == sfs_pkg::ACT_TICK);
    assign out_load  = (state_reg == S_OUT) && (!m_valid_reg || m_ready);

    // ------------------------------------------------------------------
    // configuration clamps: zero acts as one, frame count caps at MAX_FRAMES, widths cap at 4096
    // ------------------------------------------------------------------
    always_comb begin
        if (sheet_width_reg == '0) begin
            sw_c = DW'(1);
        end else if (sheet_width_reg > sfs_pkg::DIM_MAX) begin
            sw_c = sfs_pkg::DIM_MAX;
        end else begin
            sw_c = sheet_width_reg;
        end
        if (frame_width_reg == '0) begin
            fw_c = DW'(1);
        end else if (frame_width_reg > sfs_pkg::DIM_MAX) begin
            fw_c = sfs_pkg::DIM_MAX;
        end else begin
            fw_c = frame_width_reg;
        end
        fc32 = 32'(frame_count_reg);
        if (fc32 == 32'd0) begin
            cnt_c = CNT_W'(1);
        end else if (fc32 > 32'(MAX_FRAMES)) begin
            cnt_c = CNT_W'(MAX_FRAMES);
        end else begin
            cnt_c = CNT_W'(frame_count_reg);
        end
    end

    // ------------------------------------------------------------------
    // duration table: written by write transactions, read at tick accept
    // ------------------------------------------------------------------
    assign idx32     = 32'(s_entry_index);
    assign dur32     = 32'(s_entry_duration);
    // entries beyond the table are dropped
    assign ram_we    = accept && (s_action == sfs_pkg::ACT_WRITE) &&
                       (idx32 < 32'(MAX_FRAMES));
    assign ram_waddr = idx32[FI_W-1:0];
    assign ram_wdata = dur32[TIME_BITS-1:0];

    sfs_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (MAX_FRAMES)
    ) u_dur_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (take_tick),
        .raddr (frame_index_reg),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // time decision: diff = duration - (elapsed + delta)
    // advance when the frame is due, or when one more tick would overshoot
    // by more than the wait that is left; new elapsed is then -diff
    // ------------------------------------------------------------------
    always_comb begin
        dbl_diff = {diff_reg, 1'b0};
        delta_x  = signed'((XW+1)'(delta_reg));
        adv_c    = (diff_reg <= 0) || (delta_x > dbl_diff);
        esel     = adv_c ? -diff_reg : e_reg;
        if (esel > ET_HI) begin
            esat = ET_HI;
        end else if (esel < ET_LO) begin
            esat = ET_LO;
        end else begin
            esat = esel;
        end
    end

    // ------------------------------------------------------------------
    // divider A: frames per row first, then row of the current frame
    // divider B: x position modulo sheet width
    // divider C: next frame index modulo frame count
    // ------------------------------------------------------------------
    assign a_start    = (state_reg == S_START) || (state_reg == S_ROW);
    assign a_dividend = (state_reg == S_ROW) ? DW'(cur_reg) : sw_reg;
    assign a_divisor  = (state_reg == S_ROW) ? per_row_reg : fw_reg;
    assign b_start    = (state_reg == S_START);
    assign c_start    = (state_reg == S_START);

    sfs_div #(
        .N (DW),
        .D (DW)
    ) u_div_a (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (a_start),
        .dividend  (a_dividend),
        .divisor   (a_divisor),
        .busy      (a_busy),
        .quotient  (a_quo),
        .remainder (a_rem)
    );

    sfs_div #(
        .N (PX_W),
        .D (DW)
    ) u_div_b (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (b_start),
        .dividend  (px_reg),
        .divisor   (sw_reg),
        .busy      (b_busy),
        .quotient  (b_quo),
        .remainder (b_rem)
    );

    sfs_div #(
        .N (CNT_W),
        .D (CNT_W)
    ) u_div_c (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (c_start),
        .dividend  (CNT_W'(cur_reg) + CNT_W'(1)),
        .divisor   (cnt_reg),
        .busy      (c_busy),
        .quotient  (c_quo),
        .remainder (c_rem)
    );

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (take_tick) begin
                    state_next = S_PREP;
                end
            end
            S_PREP:  state_next = S_START;
            S_START: state_next = S_ROWPR;
            S_ROWPR: begin
                if (!a_busy) begin
                    state_next = S_ROW;
                end
            end
            S_ROW:   state_next = S_WAIT;
            S_WAIT: begin
                if (!a_busy && !b_busy && !c_busy) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);

    // saturated y and truncated frame number for the result
    assign sy32  = 32'(sy_reg);
    assign cur32 = 32'(cur_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            sheet_width_reg  <= sfs_pkg::SHEET_WIDTH_RST;
            frame_width_reg  <= sfs_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= sfs_pkg::FRAME_HEIGHT_RST;
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            frame_count_reg  <= sfs_pkg::FRAME_COUNT_RST;
            frame_index_reg  <= '0;
            elapsed_reg      <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                unique case (cfg_index)
                    sfs_pkg::REG_SHEET_WIDTH:  sheet_width_reg  <= cfg_wdata;
                    sfs_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                    sfs_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                    sfs_pkg::REG_ORIGIN_X:
                        origin_x_reg <= cfg_wdata[sfs_pkg::ORG_W-1:0];
                    sfs_pkg::REG_ORIGIN_Y:
                        origin_y_reg <= cfg_wdata[sfs_pkg::ORG_W-1:0];
                    sfs_pkg::REG_FRAME_COUNT:
                        frame_count_reg <= cfg_wdata[sfs_pkg::FCNT_W-1:0];
                    default: ;
                endcase
            end

            // restart clears index and time at once
            if (accept && (s_action == sfs_pkg::ACT_RESTART)) begin
                frame_index_reg <= '0;
                elapsed_reg     <= '0;
            end

            // commit the tick while its result goes to the output register
            if (out_load) begin
                elapsed_reg <= enew_reg;
                if (adv_reg) begin
                    frame_index_reg <= c_rem[FI_W-1:0];
                end
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end

        // working registers, no reset needed
        if (take_tick) begin
            cur_reg   <= frame_index_reg;
            delta_reg <= s_delta_us;
            e_reg     <= XW'(elapsed_reg) + signed'(XW'(s_delta_us));
            sw_reg    <= sw_c;
            fw_reg    <= fw_c;
            cnt_reg   <= cnt_c;
        end
        if (state_reg == S_PREP) begin
            diff_reg <= signed'(XW'(ram_rdata)) - e_reg;
            px_reg   <= PX_W'(cur_reg) * PX_W'(fw_reg) + PX_W'(origin_x_reg);
        end
        if (state_reg == S_START) begin
            adv_reg  <= adv_c;
            enew_reg <= esat[ET_W-1:0];
        end
        if ((state_reg == S_ROWPR) && !a_busy) begin
            // a sheet narrower than one frame still holds one frame per row
            per_row_reg <= (a_quo == '0) ? DW'(1) : a_quo;
        end
        if ((state_reg == S_WAIT) && !a_busy) begin
            sy_reg <= PX_W'(a_quo[FI_W-1:0]) * PX_W'(frame_height_reg) +
                      PX_W'(origin_y_reg);
        end
        if (out_load) begin
            src_x_reg    <= b_rem[sfs_pkg::SRCX_W-1:0];
            src_y_reg    <= (sy32 > sfs_pkg::SRC_Y_MAX) ?
                            sfs_pkg::SRC_Y_MAX[sfs_pkg::SRCY_W-1:0] :
                            sy32[sfs_pkg::SRCY_W-1:0];
            shown_reg    <= cur32[sfs_pkg::SHOWN_W-1:0];
            advanced_reg <= adv_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_src_x       = src_x_reg;
    assign m_src_y       = src_y_reg;
    assign m_shown_frame = shown_reg;
    assign m_advanced    = advanced_reg;

endmodule

[rtl/sfs_ram.sv]
module sfs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/sfs_div.sv]
// restoring divider, one quotient bit per cycle
module sfs_div #(
    parameter int N = 13,
    parameter int D = 13
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [D-1:0] divisor,
    output logic         busy,
    output logic [N-1:0] quotient,
    output logic [D-1:0] remainder
);

    localparam int CW = $clog2(N + 1);

    logic          busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [N-1:0]  quo_reg, quo_next;
    logic [D-1:0]  rem_reg, rem_next;
    logic [D-1:0]  dsr_reg, dsr_next;
    logic [D:0]    trial;
    logic [D:0]    diff;

    always_comb begin
        trial     = {rem_reg, quo_reg[N-1]};
        diff      = trial - {1'b0, dsr_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(N);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = diff[D-1:0];
                quo_next = {quo_reg[N-2:0], 1'b1};
            end else begin
                rem_next = trial[D-1:0];
                quo_next = {quo_reg[N-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[rtl/sfs_checker.sv]
module sfs_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic [sfs_pkg::ACT_W-1:0]    s_action,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [sfs_pkg::SRCX_W-1:0]   m_src_x,
    input logic [sfs_pkg::SRCY_W-1:0]   m_src_y,
    input logic [sfs_pkg::SHOWN_W-1:0]  m_shown_frame,
    input logic                         m_advanced
);

    // no result is pending right after reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_src_x) && $stable(m_src_y) &&
            $stable(m_shown_frame) && $stable(m_advanced))
        else $error("stalled result changed");

    // table writes, restarts and unused action codes leave the input ready
    a_short_ops: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_action != sfs_pkg::ACT_TICK) |=> s_ready)
        else $error("input not ready after one-cycle transaction");

    // a tick keeps the input side busy
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_action == sfs_pkg::ACT_TICK) |=> !s_ready)
        else $error("input ready right after tick");

    // a new result only comes out of a busy period
    a_result_from_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared while idle");

endmodule

bind sprite_frame_sequencer sfs_checker u_sfs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_action      (s_action),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_src_x       (m_src_x),
    .m_src_y       (m_src_y),
    .m_shown_frame (m_shown_frame),
    .m_advanced    (m_advanced)
);

[tb/sv/tb_sprite_frame_sequencer.sv]
`timescale 1ns / 100ps

module tb_sprite_frame_sequencer;

    localparam int MAX_FRAMES = 64;
    localparam int TIME_BITS  = 24;
    // a tick keeps the input busy; writes and restarts do not
    localparam int DRAIN_CYCLES = 40;
    localparam int NUM_PHASES = 12;
    localparam int ITEMS_PER_PHASE = 152;
    localparam longint ELAPSED_MAX = (longint'(1) << (TIME_BITS + 1)) - 1;

    // field widths
    localparam int CFG_IDX_W = sfs_pkg::CFG_IDX_W;
    localparam int CFG_W     = sfs_pkg::CFG_W;
    localparam int DIM_W     = sfs_pkg::DIM_W;
    localparam int ORG_W     = sfs_pkg::ORG_W;
    localparam int FCNT_W    = sfs_pkg::FCNT_W;
    localparam int ACT_W     = sfs_pkg::ACT_W;
    localparam int DELTA_W   = sfs_pkg::DELTA_W;
    localparam int EIDX_W    = sfs_pkg::EIDX_W;
    localparam int EDUR_W    = sfs_pkg::EDUR_W;
    localparam int SRCX_W    = sfs_pkg::SRCX_W;
    localparam int SRCY_W    = sfs_pkg::SRCY_W;
    localparam int SHOWN_W   = sfs_pkg::SHOWN_W;

    // action code the block ignores
    localparam sfs_pkg::action_t ACT_UNUSED = 2'd3;

    // one result transaction
    typedef struct packed {
        logic [SRCX_W-1:0]  src_x;
        logic [SRCY_W-1:0]  src_y;
        logic [SHOWN_W-1:0] shown;
        logic               adv;
    } frame_res_t;

    // one full register setting, written as raw port data
    typedef struct packed {
        logic [CFG_W-1:0] sheet;
        logic [CFG_W-1:0] fw;
        logic [CFG_W-1:0] fh;
        logic [CFG_W-1:0] ox;
        logic [CFG_W-1:0] oy;
        logic [CFG_W-1:0] cnt;
    } setting_t;

    typedef enum logic {ROW_ITEM, ROW_SETTING} row_kind_t;

    // one row of the directed table
    typedef struct packed {
        row_kind_t           kind;
        sfs_pkg::action_t    action;
        logic [DELTA_W-1:0]  delta;
        logic [EIDX_W-1:0]   eidx;
        logic [EDUR_W-1:0]   edur;
        setting_t            setting;
        logic                lit_valid;
        frame_res_t          lit;
    } stim_row_t;

    // how durations and tick deltas relate in a random phase
    typedef enum {PACE_ZERO, PACE_VIDEO, PACE_WIDE} pace_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [ACT_W-1:0]     s_action = sfs_pkg::ACT_TICK;
    logic [DELTA_W-1:0]   s_delta_us = '0;
    logic [EIDX_W-1:0]    s_entry_index = '0;
    logic [EDUR_W-1:0]    s_entry_duration = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [SRCX_W-1:0]    m_src_x;
    logic [SRCY_W-1:0]    m_src_y;
    logic [SHOWN_W-1:0]   m_shown_frame;
    logic                 m_advanced;

    sprite_frame_sequencer #(
        .MAX_FRAMES(MAX_FRAMES),
        .TIME_BITS (TIME_BITS)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_delta_us      (s_delta_us),
        .s_entry_index   (s_entry_index),
        .s_entry_duration(s_entry_duration),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_src_x         (m_src_x),
        .m_src_y         (m_src_y),
        .m_shown_frame   (m_shown_frame),
        .m_advanced      (m_advanced)
    );

    // predictor copy of the registers
    logic [DIM_W-1:0]  cfg_sheet_w = sfs_pkg::SHEET_WIDTH_RST;
    logic [DIM_W-1:0]  cfg_frame_w = sfs_pkg::FRAME_WIDTH_RST;
    logic [DIM_W-1:0]  cfg_frame_h = sfs_pkg::FRAME_HEIGHT_RST;
    logic [ORG_W-1:0]  cfg_org_x = '0;
    logic [ORG_W-1:0]  cfg_org_y = '0;
    logic [FCNT_W-1:0] cfg_frame_cnt = sfs_pkg::FRAME_COUNT_RST;

    // predictor copy of the animation state
    logic [EIDX_W-1:0]             frame_idx = '0;
    logic signed [TIME_BITS+1:0]   elapsed_us = '0;
    logic [EDUR_W-1:0]             dur_table [MAX_FRAMES];
    // entries never written must never be read by a tick
    bit                            dur_known [MAX_FRAMES];

    frame_res_t  pending_frames [$];
    stim_row_t   directed_rows [$];
    int unsigned bad_results = 0;
    bit          idling_on = 1'b1;
    frame_res_t  want, got;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // expected result of one accepted transaction, state updated in place
    function automatic bit step_sequencer(input sfs_pkg::action_t act,
                                          input logic [DELTA_W-1:0] delta,
                                          input logic [EIDX_W-1:0] idx,
                                          input logic [EDUR_W-1:0] dur, output frame_res_t res);
        longint sw, fw, cnt, per_row, cur, sx, sy, d, span, e;
        bit adv;
        res = '0;
        step_sequencer = 1'b0;
        case (act)
            sfs_pkg::ACT_WRITE: begin
                // table holds all TIME_BITS of the duration; every index is in range
                dur_table[idx] = dur;
                dur_known[idx] = 1'b1;
            end
            sfs_pkg::ACT_RESTART: begin
                frame_idx = '0;
                elapsed_us = '0;
            end
            sfs_pkg::ACT_TICK: begin
                // zero widths act as one, oversized ones as the maximum
                sw = (cfg_sheet_w == 0) ? 1 :
                     ((cfg_sheet_w > sfs_pkg::DIM_MAX) ? sfs_pkg::DIM_MAX : cfg_sheet_w);
                fw = (cfg_frame_w == 0) ? 1 :
                     ((cfg_frame_w > sfs_pkg::DIM_MAX) ? sfs_pkg::DIM_MAX : cfg_frame_w);
                cnt = (cfg_frame_cnt == 0) ? 1 :
                      ((cfg_frame_cnt > MAX_FRAMES) ? MAX_FRAMES : cfg_frame_cnt);
                per_row = sw / fw;
                // sheet narrower than one frame still holds one frame per row
                if (per_row == 0)
                    per_row = 1;
                cur = frame_idx;
                sx = (cur * fw + cfg_org_x) % sw;
                sy = (cur / per_row) * cfg_frame_h + cfg_org_y;
                if (sy > sfs_pkg::SRC_Y_MAX)
                    sy = sfs_pkg::SRC_Y_MAX;

                d = delta;
                span = dur_table[cur];
                e = elapsed_us;
                e = e + d;
                // regular advance, or early advance when waiting would overshoot more
                adv = (span <= e) || (d > 2 * (span - e));
                if (adv)
                    e = e - span;
                if (e > ELAPSED_MAX)
                    e = ELAPSED_MAX;
                if (e < -ELAPSED_MAX - 1)
                    e = -ELAPSED_MAX - 1;
                elapsed_us = e[TIME_BITS+1:0];
                // an index above a lowered count still wraps, as (index + 1) modulo the count
                if (adv)
                    frame_idx = EIDX_W'((cur + 1) % cnt);

                res.src_x = sx[SRCX_W-1:0];
                res.src_y = sy[SRCY_W-1:0];
                res.shown = cur[SHOWN_W-1:0];
                res.adv = adv;
                step_sequencer = 1'b1;
            end
            default: ;
        endcase
    endfunction

    function automatic setting_t make_setting(input int unsigned sheet, fw, fh, ox, oy, cnt);
        setting_t s;
        s.sheet = CFG_W'(sheet);
        s.fw = CFG_W'(fw);
        s.fh = CFG_W'(fh);
        s.ox = CFG_W'(ox);
        s.oy = CFG_W'(oy);
        s.cnt = CFG_W'(cnt);
        return s;
    endfunction

    // directed table builders
    function automatic void add_item(input sfs_pkg::action_t act,
                                     input int unsigned delta, idx, dur);
        stim_row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.action = act;
        r.delta = DELTA_W'(delta);
        r.eidx = EIDX_W'(idx);
        r.edur = EDUR_W'(dur);
        directed_rows.push_back(r);
    endfunction

    function automatic void add_checked(input int unsigned delta, x, y, shown, adv);
        stim_row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.action = sfs_pkg::ACT_TICK;
        r.delta = DELTA_W'(delta);
        r.lit_valid = 1'b1;
        r.lit.src_x = SRCX_W'(x);
        r.lit.src_y = SRCY_W'(y);
        r.lit.shown = SHOWN_W'(shown);
        r.lit.adv = adv[0];
        directed_rows.push_back(r);
    endfunction

    function automatic void add_setting(input setting_t cfg);
        stim_row_t r;
        r = '0;
        r.kind = ROW_SETTING;
        r.setting = cfg;
        directed_rows.push_back(r);
    endfunction

    function automatic logic [EDUR_W-1:0] pick_duration(input pace_t pace);
        case (pace)
            PACE_ZERO:  return EDUR_W'(($urandom_range(0, 7) == 0) ? $urandom_range(1, 100) : 0);
            PACE_VIDEO: return EDUR_W'($urandom_range(1000, 60000));
            default:    return EDUR_W'(($urandom_range(0, 1) == 0) ?
                                       $urandom_range(0, 24'hFFFFFF) : $urandom_range(0, 5000));
        endcase
    endfunction

    function automatic logic [DELTA_W-1:0] pick_delta(input pace_t pace);
        case (pace)
            PACE_ZERO:  return ($urandom_range(0, 3) == 0) ?
                               DELTA_W'($urandom_range(0, 20'hFFFFF)) : 20'hFFFFF;
            PACE_VIDEO: begin
                if ($urandom_range(0, 15) == 0)
                    return ($urandom_range(0, 1) == 0) ? 20'h0 : 20'hFFFFF;
                return DELTA_W'($urandom_range(8000, 34000));
            end
            default:    return DELTA_W'(($urandom_range(0, 1) == 0) ?
                                        $urandom_range(0, 20'hFFFFF) : $urandom_range(0, 5000));
        endcase
    endfunction

    // present one input transaction, wait for it to be taken, then predict
    task automatic send_item(input sfs_pkg::action_t act, input logic [DELTA_W-1:0] delta,
                             input logic [EIDX_W-1:0] idx, input logic [EDUR_W-1:0] dur,
                             input logic lit_valid, input frame_res_t lit);
        frame_res_t res;
        int unsigned gap;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_delta_us <= delta;
        s_entry_index <= idx;
        s_entry_duration <= dur;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (step_sequencer(act, delta, idx, dur, res))
            pending_frames.push_back(lit_valid ? lit : res);
    endtask

    task automatic write_reg(input sfs_pkg::cfg_idx_t idx, input logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // registers change only once the block has gone quiet
    task automatic apply_setting(input setting_t cfg);
        s_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge aclk);
        // a trailing write or restart may still be in flight
        repeat (DRAIN_CYCLES) @(posedge aclk);
        write_reg(sfs_pkg::REG_SHEET_WIDTH, cfg.sheet);
        write_reg(sfs_pkg::REG_FRAME_WIDTH, cfg.fw);
        write_reg(sfs_pkg::REG_FRAME_HEIGHT, cfg.fh);
        write_reg(sfs_pkg::REG_ORIGIN_X, cfg.ox);
        write_reg(sfs_pkg::REG_ORIGIN_Y, cfg.oy);
        write_reg(sfs_pkg::REG_FRAME_COUNT, cfg.cnt);
        cfg_we <= 1'b0;
        cfg_sheet_w = cfg.sheet;
        cfg_frame_w = cfg.fw;
        cfg_frame_h = cfg.fh;
        cfg_org_x = cfg.ox[ORG_W-1:0];
        cfg_org_y = cfg.oy[ORG_W-1:0];
        cfg_frame_cnt = cfg.cnt[FCNT_W-1:0];
    endtask

    // result side backpressure in random bursts
    initial begin : result_stall
        int unsigned hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (hold != 0) begin
                hold = hold - 1;
                m_ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 9) == 0) begin
                hold = $urandom_range(0, 17);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // compare every result transaction with the oldest prediction
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            got = {m_src_x, m_src_y, m_shown_frame, m_advanced};
            if (pending_frames.size() == 0) begin
                $display("%0t: result with nothing pending, actual x=%0d y=%0d frame=%0d adv=%0d",
                         $time, got.src_x, got.src_y, got.shown, got.adv);
                bad_results = bad_results + 1;
            end else begin
                want = pending_frames.pop_front();
                if (got !== want) begin
                    $display("%0t: result mismatch, expected x=%0d y=%0d frame=%0d adv=%0d",
                             $time, want.src_x, want.src_y, want.shown, want.adv);
                    $display("%0t:                  actual x=%0d y=%0d frame=%0d adv=%0d",
                             $time, got.src_x, got.src_y, got.shown, got.adv);
                    bad_results = bad_results + 1;
                end
            end
        end
    end

    // watchdog, several times the slowest legal run
    initial begin
        #8_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        setting_t    cfg;
        pace_t       pace;
        int unsigned sent;
        int unsigned pick;

        foreach (dur_known[i]) begin
            dur_known[i] = 1'b0;
            dur_table[i] = '0;
        end

        // directed part, registers at their reset values
        add_item(sfs_pkg::ACT_WRITE, 0, 0, 0);
        // zero duration with zero delta still advances, single frame wraps to itself
        add_checked(0, 0, 0, 0, 1);
        add_item(sfs_pkg::ACT_WRITE, 0, 0, 24'hFFFFFF);
        // longest delta against longest duration, no advance
        add_checked(20'hFFFFF, 0, 0, 0, 0);
        // unused action code with all fields high, no result
        add_item(ACT_UNUSED, 20'hFFFFF, 63, 24'hFFFFFF);
        add_item(sfs_pkg::ACT_RESTART, 20'hFFFFF, 63, 24'hFFFFFF);
        add_item(sfs_pkg::ACT_WRITE, 0, 63, 24'hFFFFFF);
        // zero widths act as one, origin bit above its width dropped, zero count
        add_setting(make_setting(0, 0, 13'h1FFF, 13'h1FFF, 13'h1FFF, 0));
        add_checked(0, 0, 4095, 0, 0);
        add_item(sfs_pkg::ACT_WRITE, 0, 0, 1000);
        add_item(sfs_pkg::ACT_TICK, 999, 0, 0);
        // overshoot carried into the next frame
        add_item(sfs_pkg::ACT_TICK, 1100, 0, 0);
        // early advance, elapsed time goes negative
        add_item(sfs_pkg::ACT_TICK, 700, 0, 0);
        // sheet narrower than a frame, count above the table size
        add_setting(make_setting(16, 4096, 8191, 0, 0, 127));
        add_item(sfs_pkg::ACT_WRITE, 0, 1, 0);
        add_item(sfs_pkg::ACT_TICK, 200, 0, 0);
        add_item(sfs_pkg::ACT_TICK, 2000, 0, 0);
        add_item(sfs_pkg::ACT_TICK, 0, 0, 0);
        add_item(sfs_pkg::ACT_WRITE, 0, 2, 1);
        add_item(sfs_pkg::ACT_TICK, 20'hFFFFF, 0, 0);
        // count lowered below the current index
        add_setting(make_setting(4096, 64, 64, 100, 200, 2));
        add_item(sfs_pkg::ACT_WRITE, 0, 3, 0);
        add_item(sfs_pkg::ACT_TICK, 5, 0, 0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_SETTING)
                apply_setting(directed_rows[i].setting);
            else
                send_item(directed_rows[i].action, directed_rows[i].delta, directed_rows[i].eidx,
                          directed_rows[i].edur, directed_rows[i].lit_valid, directed_rows[i].lit);
        end

        // random phases, each with its own setting and pacing
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == 0) begin
                // all registers at zero
                cfg = make_setting(0, 0, 0, 0, 0, 0);
                pace = PACE_VIDEO;
            end else if (p == 1) begin
                // all data bits set: tall frames saturate, elapsed time saturates
                cfg = make_setting(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF);
                pace = PACE_ZERO;
            end else begin
                cfg = make_setting(
                    ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 4096),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 256),
                    $urandom_range(0, 8191), $urandom_range(0, 8191), $urandom_range(0, 8191),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 8));
                pace = pace_t'($urandom_range(0, 2));
            end
            // the closing phase runs without any idling
            idling_on = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            apply_setting(cfg);
            sent = 0;
            if ($urandom_range(0, 1) == 0) begin
                send_item(sfs_pkg::ACT_RESTART, DELTA_W'($urandom), EIDX_W'($urandom),
                          EDUR_W'($urandom), 1'b0, '0);
                sent = sent + 1;
            end
            while (sent < ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 80) begin
                    // load the current frame's duration before it is first shown
                    if (!dur_known[frame_idx]) begin
                        send_item(sfs_pkg::ACT_WRITE, DELTA_W'($urandom), frame_idx,
                                  pick_duration(pace), 1'b0, '0);
                        sent = sent + 1;
                    end
                    send_item(sfs_pkg::ACT_TICK, pick_delta(pace), EIDX_W'($urandom),
                              EDUR_W'($urandom), 1'b0, '0);
                end else if (pick < 91) begin
                    send_item(sfs_pkg::ACT_WRITE, DELTA_W'($urandom), EIDX_W'($urandom),
                              pick_duration(pace), 1'b0, '0);
                end else if (pick < 97) begin
                    send_item(sfs_pkg::ACT_RESTART, DELTA_W'($urandom), EIDX_W'($urandom),
                              EDUR_W'($urandom), 1'b0, '0);
                end else begin
                    // ignored by the block, not counted
                    send_item(ACT_UNUSED, DELTA_W'($urandom), EIDX_W'($urandom),
                              EDUR_W'($urandom), 1'b0, '0);
                    sent = sent - 1;
                end
                sent = sent + 1;
            end
        end

        s_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (bad_results == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/sfs_pkg.sv
rtl/sfs_ram.sv
rtl/sfs_div.sv
rtl/sprite_frame_sequencer.sv
rtl/sfs_checker.sv
tb/sv/tb_sprite_frame_sequencer.sv
